[rtl/four_level_page_table_walker_assert.svh]
// assertion macros for the page table walker checker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define PTW_ASSERT_IMP(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define PTW_ASSERT_NXT(lbl, clk, a, b, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error(msg);

`endif

[rtl/ptw_pkg.sv]
// types, constants and helpers for the page table walker
package ptw_pkg;

  localparam int VA_W   = 48;
  localparam int WORD_W = 64;
  localparam int WI_W   = 16;
  localparam int LIM_W  = 20;
  localparam int ROOT_W = 19;
  localparam int IDX_W  = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [LIM_W-1:0] PAGE_BYTES = 20'd4096;
  localparam logic [LIM_W-1:0] MEM_SIZE_RESET = 20'd524288;

  localparam logic [WORD_W-1:0] BASE_MASK = 64'h0000_FFFF_FFFF_F000;
  localparam int LARGE_BIT = 7;

  // input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 2'd1;

  typedef struct packed {
    logic              op;
    logic [WI_W-1:0]   word_index;
    logic [WORD_W-1:0] write_data;
    logic [VA_W-1:0]   virt_addr;
  } req_t;

  typedef struct packed {
    logic [VA_W-1:0] phys_addr;
    logic            fault;
    logic            large_page;
  } rsp_t;

  // classified item as held in the queue
  typedef struct packed {
    req_t                req;
    logic [ROOT_W-4:0]   root_word;
    logic                root_fault;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage

[rtl/four_level_page_table_walker.sv]
// top level of the four-level page table walker
//
// Command channel: drive request and raise start; the beat is taken at a
// clock edge where start is high and busy is low. Op 0 stores write_data at
// word_index of the table image, op 1 translates virt_addr through four
// levels of tables starting at the root register.
// Result channel: every beat gives exactly one result, in order, on rsp for
// the single cycle in which done is high. The receiver cannot stall.
// Configuration: cfg_write with cfg_index 0 sets the root table base, index 1
// sets the memory size; write them only while no command is in flight.
// Timing: writes stream at one per cycle while no walk is running. A
// translation leaves the queue and addresses the root table, then reads one
// table per level (the reads depend on each other through the single table
// memory port) until it faults or ends, then loads the result register.
// A two-entry queue takes new beats while a walk runs; busy is high only
// when that queue is full.
// Reset (rst, synchronous) empties the queue, stops any walk and sets the
// root to 0 and memory size to 512 KiB; table contents are kept and are
// undefined until written. MEM_WORDS must be a power of two.
module four_level_page_table_walker #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ptw_pkg::req_t                 request,
  output logic                          done,
  output ptw_pkg::rsp_t                 rsp,
  input  logic                          cfg_write,
  input  logic [ptw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptw_pkg::LIM_W-1:0]     cfg_data
);
  import ptw_pkg::*;

  logic              push;
  logic              pop;
  qent_t             entry;
  qent_t             head;
  q_status_t         qstat;
  logic [LIM_W-1:0]  limit;

  ptw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .entry     (entry),
    .limit     (limit)
  );

  ptw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  ptw_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .limit (limit),
    .done  (done),
    .rsp   (rsp)
  );

endmodule

[rtl/ptw_front.sv]
// front end: configuration registers, range limit and item classification
module ptw_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  ptw_pkg::req_t                    request,
  input  logic                             cfg_write,
  input  logic [ptw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptw_pkg::LIM_W-1:0]        cfg_data,
  input  ptw_pkg::q_status_t               qstat,
  output logic                             push,
  output ptw_pkg::qent_t                   entry,
  output logic [ptw_pkg::LIM_W-1:0]        limit
);
  import ptw_pkg::*;

  logic [ROOT_W-1:0] root_table_base;
  logic [LIM_W-1:0]  mem_size;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_base <= '0;
      mem_size        <= MEM_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROOT:     root_table_base <= cfg_data[ROOT_W-1:0];
        CFG_MEM_SIZE: mem_size        <= cfg_data;
        default: ;
      endcase
    end
  end

  // highest valid table base, saturating at zero
  assign limit = (mem_size >= PAGE_BYTES) ? (mem_size - PAGE_BYTES) : '0;

  // accept while the queue has room
  assign busy = qstat.full;
  assign push = start && !qstat.full;

  // classify: root word address and root range check
  always_comb begin
    entry.req        = request;
    entry.root_word  = root_table_base[ROOT_W-1:3];
    entry.root_fault = (request.op == OP_XLATE) && ({1'b0, root_table_base} > limit);
  end

endmodule

[rtl/ptw_queue.sv]
// two-entry queue between front end and walker
module ptw_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ptw_pkg::qent_t     wr_entry,
  input  logic               pop,
  output ptw_pkg::qent_t     head,
  output ptw_pkg::q_status_t qstat
);
  import ptw_pkg::*;

  qent_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // slot storage, no reset on payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);

endmodule

[rtl/ptw_back.sv]
// back end: table memory and the level-by-level walk
module ptw_back #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ptw_pkg::qent_t            head,
  input  ptw_pkg::q_status_t        qstat,
  output logic                      pop,
  input  logic [ptw_pkg::LIM_W-1:0] limit,
  output logic                      done,
  output ptw_pkg::rsp_t             rsp
);
  import ptw_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int XW = (AW > 18) ? AW : 18;

  // walk levels
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [1:0]        lvl, lvl_next;
  logic [VA_W-1:0]   va;
  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] ent;
  logic [WORD_W-1:0] base;
  logic              bad;
  logic              rd_en;
  logic [XW-1:0]     rd_word;
  logic              we;
  logic              fin;
  rsp_t              fin_rsp;

  function automatic logic [IDX_W-1:0] idx_at(input logic [VA_W-1:0] a, input logic [1:0] l);
    logic [IDX_W-1:0] r;
    unique case (l)
      LVL_PML4: r = a[47:39];
      LVL_PDPT: r = a[38:30];
      LVL_PD:   r = a[29:21];
      default:  r = a[20:12];
    endcase
    return r;
  endfunction

  // decode the entry that just came out of the memory
  assign ent  = swap_bytes(rdata);
  assign base = ent & BASE_MASK;
  assign bad  = (base == '0) || (base > {{(WORD_W-LIM_W){1'b0}}, limit});

  assign pop = (state == ST_IDLE) && !qstat.empty;

  // walk control
  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    rd_en      = 1'b0;
    rd_word    = '0;
    we         = 1'b0;
    fin        = 1'b0;
    fin_rsp    = '0;
    unique case (state)
      ST_IDLE: begin
        if (!qstat.empty) begin
          if (head.req.op == OP_WRITE) begin
            we  = (32'(head.req.word_index) < MEM_WORDS);
            fin = 1'b1;
          end else if (head.root_fault) begin
            fin           = 1'b1;
            fin_rsp.fault = 1'b1;
          end else begin
            rd_en      = 1'b1;
            rd_word    = XW'(head.root_word) + XW'(idx_at(head.req.virt_addr, LVL_PML4));
            lvl_next   = LVL_PML4;
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (bad) begin
          fin           = 1'b1;
          fin_rsp.fault = 1'b1;
          state_next    = ST_IDLE;
        end else if ((lvl == LVL_PD) && ent[LARGE_BIT]) begin
          fin                = 1'b1;
          fin_rsp.phys_addr  = {base[VA_W-1:21], va[20:0]};
          fin_rsp.large_page = 1'b1;
          state_next         = ST_IDLE;
        end else if (lvl == LVL_PT) begin
          fin               = 1'b1;
          fin_rsp.phys_addr = {base[VA_W-1:12], va[11:0]};
          state_next        = ST_IDLE;
        end else begin
          // base is within limit here, so bits 19:3 hold its word address
          rd_en    = 1'b1;
          rd_word  = XW'(base[LIM_W-1:3]) + XW'(idx_at(va, lvl + 2'd1));
          lvl_next = lvl + 2'd1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(head.req.word_index)] <= head.req.write_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_word[AW-1:0]];
    end
  end

  // control state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lvl   <= LVL_PML4;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      done  <= fin;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) va <= head.req.virt_addr;
    if (fin) rsp <= fin_rsp;
  end

endmodule

[rtl/ptw_checker.sv]
// port-level checks for the page table walker, bound to the top level
`include "four_level_page_table_walker_assert.svh"

module ptw_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input ptw_pkg::rsp_t rsp
);
  import ptw_pkg::*;

  logic [2:0] pending;

  // beats taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + {2'b00, (start && !busy)} - {2'b00, done};
    end
  end

  `PTW_ASSERT_IMP(fault_clean, clk, rst, done && rsp.fault, (rsp.phys_addr == '0) && !rsp.large_page, "fault result carries address or large page")
  `PTW_ASSERT_IMP(no_orphan, clk, rst, done, pending != 3'd0, "result without an outstanding beat")
  `PTW_ASSERT_IMP(pending_bound, clk, rst, 1'b1, pending <= 3'd4, "more beats in flight than storage allows")
  `PTW_ASSERT_NXT(reset_quiet, clk, rst, !busy && !done, "busy or done right after reset")

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

[tb/tb_four_level_page_table_walker.sv]
// self-checking testbench for the four-level page table walker
module tb_four_level_page_table_walker;
  import ptw_pkg::*;

  localparam int MEM_WORDS = 65536;
  localparam int ITEMS = 1800;
  localparam int PHASE_QUOTA = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum {K_PICK, K_VALID, K_LARGE, K_ZERO, K_HIGH, K_EDGE} entry_kind_e;

  // reverse the byte order of a table word
  function automatic logic [63:0] byte_reverse(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[56-8*i +: 8];
    end
    return r;
  endfunction

  // table image, register copy and expected results of every beat
  class walk_checker;
    logic [63:0] image [MEM_WORDS];
    bit          loaded [MEM_WORDS];
    logic [18:0] root;
    logic [19:0] mem_bytes;
    rsp_t        expected_xlat [$];
    int          failures;

    function new();
      root      = '0;
      mem_bytes = MEM_SIZE_RESET;
      failures  = 0;
    endfunction

    function logic [19:0] limit();
      return (mem_bytes >= PAGE_BYTES) ? mem_bytes - PAGE_BYTES : '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [19:0] val);
      if (idx == CFG_ROOT) root = val[18:0];
      else if (idx == CFG_MEM_SIZE) mem_bytes = val;
    endfunction

    // walk the tables; miss names the first never-written word the walk would read
    function void predict_walk(input logic [47:0] va, output rsp_t r, output int miss,
                               output int miss_lvl);
      logic [19:0] lim;
      logic [63:0] base, ent, byte_addr;
      logic [8:0]  idx;
      int          waddr;
      r        = '0;
      miss     = -1;
      miss_lvl = 0;
      lim      = limit();
      if (root > lim) begin
        r.fault = 1'b1;
        return;
      end
      base = 64'(root);
      for (int lvl = 1; lvl <= 4; lvl++) begin
        idx       = 9'(va >> (48 - 9*lvl));
        byte_addr = base + {idx, 3'b000};
        waddr     = int'((byte_addr >> 3) % MEM_WORDS);
        if (!loaded[waddr]) begin
          miss     = waddr;
          miss_lvl = lvl;
          r        = '0;
          return;
        end
        ent  = byte_reverse(image[waddr]);
        base = ent & BASE_MASK;
        if (base == 0 || base > 64'(lim)) begin
          r.fault = 1'b1;
          return;
        end
        // large page ends the walk at the third level
        if (lvl == 3 && ent[LARGE_BIT]) begin
          r.phys_addr  = {base[47:21], va[20:0]};
          r.large_page = 1'b1;
          return;
        end
      end
      r.phys_addr = base[47:0] | 48'(va[11:0]);
    endfunction

    function void note_item(req_t q);
      rsp_t r;
      int   miss, lvl;
      r = '0;
      if (q.op == OP_WRITE) begin
        if (q.word_index < MEM_WORDS) begin
          image[q.word_index]  = q.write_data;
          loaded[q.word_index] = 1'b1;
        end
      end else begin
        predict_walk(q.virt_addr, r, miss, lvl);
      end
      expected_xlat.push_back(r);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_xlat.size() == 0) begin
        $error("result beat with nothing expected: phys_addr %h fault %b large_page %b",
               got.phys_addr, got.fault, got.large_page);
        failures++;
        return;
      end
      want = expected_xlat.pop_front();
      if (got.phys_addr !== want.phys_addr) begin
        $error("phys_addr expected %h got %h", want.phys_addr, got.phys_addr);
        failures++;
      end
      if (got.fault !== want.fault) begin
        $error("fault expected %b got %b", want.fault, got.fault);
        failures++;
      end
      if (got.large_page !== want.large_page) begin
        $error("large_page expected %b got %b", want.large_page, got.large_page);
        failures++;
      end
    endfunction

    function int pending();
      return expected_xlat.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 request = '0;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIM_W-1:0]     cfg_data = '0;

  walk_checker walk_sb = new();
  int          item_count = 0;
  bit          no_idle = 1'b0;
  entry_kind_e forced_kind [1:4] = '{K_PICK, K_PICK, K_PICK, K_PICK};
  int          table_words [$];
  logic [47:0] va_pool [16];

  four_level_page_table_walker #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result beats are taken at the edge that ends their cycle
  always @(posedge clk) begin
    if (!rst && done === 1'b1) walk_sb.check_result(rsp);
  end

  // mostly short gaps, a few long ones, and stretches without any
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 60) return 0;
    if (p < 90) return $urandom_range(3, 1);
    if (p < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // table entry as stored, aimed at the current memory limit
  function automatic logic [63:0] make_entry(input int lvl, input entry_kind_e kind);
    logic [63:0] e;
    int          p, top;
    top = int'(walk_sb.limit() >> 12);
    if (kind == K_PICK) begin
      p = $urandom_range(99);
      if (lvl == 3 && p < 25) kind = K_LARGE;
      else if (p < 85) kind = K_VALID;
      else if (p < 90) kind = K_ZERO;
      else if (p < 95) kind = K_HIGH;
      else kind = K_EDGE;
    end
    e = {$urandom, $urandom};
    case (kind)
      K_VALID, K_LARGE: begin
        e[47:12] = (top == 0) ? 36'd1 : 36'($urandom_range(top, 1));
      end
      K_ZERO: begin
        e[47:12] = '0;
      end
      K_HIGH: begin
        if ($urandom_range(1) == 0) e[47:12] = 36'(top + 1);
        else e[47:12] = {4'($urandom), 32'($urandom)} | 36'h100;
      end
      default: begin
        e[47:12] = 36'(top);
      end
    endcase
    if (kind == K_LARGE) e[LARGE_BIT] = 1'b1;
    else if (kind == K_VALID && lvl == 3) e[LARGE_BIT] = 1'b0;
    return byte_reverse(e);
  endfunction

  function automatic req_t noise_req();
    req_t q;
    q.op         = 1'($urandom);
    q.word_index = 16'($urandom);
    q.write_data = {$urandom, $urandom};
    q.virt_addr  = 48'({$urandom, $urandom});
    return q;
  endfunction

  // hold start until the beat is taken
  task automatic send_item(input req_t q);
    start   <= 1'b1;
    request <= q;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    walk_sb.note_item(q);
  endtask

  task automatic issue(input req_t q);
    int n;
    send_item(q);
    item_count++;
    n = gap_len();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue_write(input int widx, input logic [63:0] data);
    req_t q;
    q            = noise_req();
    q.op         = OP_WRITE;
    q.word_index = 16'(widx);
    q.write_data = data;
    issue(q);
  endtask

  // fill every table word the walk would read, then send the translation
  task automatic translate(input logic [47:0] va);
    rsp_t r;
    int   miss, lvl;
    req_t q;
    forever begin
      walk_sb.predict_walk(va, r, miss, lvl);
      if (miss < 0) break;
      issue_write(miss, make_entry(lvl, forced_kind[lvl]));
      table_words.push_back(miss);
    end
    q           = noise_req();
    q.op        = OP_XLATE;
    q.virt_addr = va;
    issue(q);
  endtask

  task automatic directed_walk(input logic [47:0] va, input entry_kind_e k1,
                               input entry_kind_e k2, input entry_kind_e k3,
                               input entry_kind_e k4);
    forced_kind = '{k1, k2, k3, k4};
    translate(va);
    forced_kind = '{K_PICK, K_PICK, K_PICK, K_PICK};
  endtask

  // wait until every result is back and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (walk_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // root, memory size, then an index the block does not decode
  task automatic load_config(input logic [19:0] root_val, input logic [19:0] size_val);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROOT;
    cfg_data  <= root_val;
    @(posedge clk);
    walk_sb.set_reg(CFG_ROOT, root_val);
    cfg_index <= CFG_MEM_SIZE;
    cfg_data  <= size_val;
    @(posedge clk);
    walk_sb.set_reg(CFG_MEM_SIZE, size_val);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 20'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [19:0] phase_root [8];
    logic [19:0] phase_size [8];
    logic [19:0] rt, sz;
    logic [47:0] va;
    int          ph, n, p, w;
    phase_root = '{20'h23000, 20'h00000, 20'hFF000, 20'h12345,
                   20'h7FFFF, 20'h00000, 20'h03000, 20'h00000};
    phase_size = '{20'h80000, 20'h80000, 20'h80000, 20'h40000,
                   20'hFFFFF, 20'h01000, 20'h08000, 20'h80000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset configuration, field extremes, each way a walk ends
    issue_write(0, 64'h0);
    translate(48'h0);
    issue_write(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    directed_walk(48'hFFFF_FFFF_FFFF, K_VALID, K_VALID, K_VALID, K_VALID);
    directed_walk({9'd1, 9'd7, 9'd300, 9'd5, 12'hABC}, K_VALID, K_VALID, K_LARGE, K_PICK);
    directed_walk({9'd2, 9'd8, 9'd9, 9'd10, 12'h123}, K_VALID, K_HIGH, K_PICK, K_PICK);
    directed_walk({9'd3, 9'd1, 9'd2, 9'd3, 12'h456}, K_VALID, K_VALID, K_VALID, K_ZERO);
    directed_walk({9'd4, 9'd511, 9'd0, 9'd511, 12'hFFF}, K_EDGE, K_EDGE, K_EDGE, K_EDGE);
    // root beyond the limit
    drain();
    load_config(20'h7FFFF, 20'h80000);
    translate({9'd5, 39'h0});
    // memory size below one page: every nonzero base faults
    drain();
    load_config(20'h00000, 20'd100);
    directed_walk({9'd6, 39'h12345}, K_VALID, K_PICK, K_PICK, K_PICK);

    // random phases over several settings
    ph = 0;
    while (item_count < ITEMS) begin
      drain();
      if (ph % 8 == 7) begin
        sz = 20'($urandom_range(20'hFFFFF, 4096));
        rt = 20'($urandom_range(sz - 4096, 0));
      end else begin
        rt = phase_root[ph % 8];
        sz = phase_size[ph % 8];
      end
      load_config(rt, sz);
      foreach (va_pool[i]) va_pool[i] = 48'({$urandom, $urandom});
      for (n = 0; n < PHASE_QUOTA && item_count < ITEMS; n++) begin
        if ($urandom_range(49) == 0) no_idle = !no_idle;
        p = $urandom_range(99);
        if (p < 72) begin
          va = va_pool[$urandom_range(15)];
          p = $urandom_range(99);
          if (p < 45) va[11:0] = 12'($urandom);
          else if (p < 65) va[20:0] = 21'($urandom);
          else if (p < 80) va[29:12] = 18'($urandom);
          else va = 48'({$urandom, $urandom});
          translate(va);
        end else if (p < 88 && table_words.size() > 0) begin
          // overwrite a word that walks already use
          w = table_words[$urandom_range(table_words.size() - 1)];
          if ($urandom_range(1) == 0) issue_write(w, make_entry($urandom_range(4, 1), K_PICK));
          else issue_write(w, {$urandom, $urandom});
        end else begin
          issue_write(int'(16'($urandom)), {$urandom, $urandom});
        end
      end
      ph++;
    end

    drain();
    if (walk_sb.failures == 0) begin
      $display("four_level_page_table_walker: match");
    end else begin
      $display("four_level_page_table_walker: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("four_level_page_table_walker: mismatch");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ptw_pkg.sv
rtl/ptw_front.sv
rtl/ptw_queue.sv
rtl/ptw_back.sv
rtl/four_level_page_table_walker.sv
rtl/ptw_checker.sv
tb/tb_four_level_page_table_walker.sv
